/* sv/quadratic_phase_chirp_rotate_macros.svh */
// assertion macros for the quadratic phase chirp rotator
`ifndef QUADRATIC_PHASE_CHIRP_ROTATE_MACROS_SVH
`define QUADRATIC_PHASE_CHIRP_ROTATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define QPCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define QPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/qpcr_pkg.sv */
// shared types, constants and trig table for the quadratic phase chirp rotator
package qpcr_pkg;

    localparam int COORD_BITS      = 12;
    localparam int SIZE_BITS       = 13;
    localparam int OFFSET_BITS     = 14;
    localparam int SQ_BITS         = 25;
    localparam int DIST_BITS       = 26;
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
    localparam int QUARTER         = 1 << QUARTER_BITS;
    localparam int TRIG_FRAC       = 17;
    localparam int TRIG_BITS       = TRIG_FRAC + 1;
    localparam int SC_BITS         = TRIG_BITS + 1;
    localparam int PIXEL_BITS      = 18;
    localparam int PROD_BITS       = PIXEL_BITS + SC_BITS;
    localparam int ACC_BITS        = PROD_BITS + 1;
    localparam int NUM_STAGES      = 6;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 32;
    localparam int IN_DATA_BITS    = 64;
    localparam int OUT_DATA_BITS   = 40;

    localparam logic [SIZE_BITS-1:0]  ROWS_RESET = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0]  COLS_RESET = SIZE_BITS'(1024);
    localparam logic [PHASE_BITS-1:0] COEF_RESET = '0;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_ROWS = 2'd0,
        CFG_IMAGE_COLS = 2'd1,
        CFG_PHASE_COEF = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] re;
        logic signed [PIXEL_BITS-1:0] im;
    } pix_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    typedef logic [QUARTER:0][TRIG_BITS-1:0] qsin_table_t;

    // quarter-wave sine, integer taylor series with 30 fraction bits
    function automatic qsin_table_t build_qsin();
        qsin_table_t     tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (longint'(k) * HALF_PI_Q30 + (64'd1 << (TABLE_ADDR_BITS - 3)))
                >> (TABLE_ADDR_BITS - 2);
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (int n = 0; n < 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n[0] == 1'b0)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            tbl[k] = TRIG_BITS'(($unsigned(acc) + (64'd1 << (29 - TRIG_FRAC)))
                                >> (30 - TRIG_FRAC));
        end
        return tbl;
    endfunction

    localparam qsin_table_t QSIN_TABLE = build_qsin();

endpackage

/* sv/qpcr_phase.sv */
// offsets from centre, squared distance and wrapped phase, three stages
module qpcr_phase (
    input  logic                           clk,
    input  qpcr_pkg::pipe_ctl_t            ctl,
    input  logic [qpcr_pkg::SIZE_BITS-1:0] image_rows,
    input  logic [qpcr_pkg::SIZE_BITS-1:0] image_cols,
    input  logic [qpcr_pkg::PHASE_BITS-1:0] phase_coef,
    input  logic [qpcr_pkg::COORD_BITS-1:0] pix_row,
    input  logic [qpcr_pkg::COORD_BITS-1:0] pix_col,
    input  qpcr_pkg::pix_t                 pix_in,
    output logic [qpcr_pkg::PHASE_BITS-1:0] phase,
    output qpcr_pkg::pix_t                 pix_out
);
    import qpcr_pkg::*;

    logic [SIZE_BITS-1:0]                    centre_row;
    logic [SIZE_BITS-1:0]                    centre_col;
    logic signed [OFFSET_BITS-1:0]           dr_next;
    logic signed [OFFSET_BITS-1:0]           dc_next;
    logic signed [OFFSET_BITS-1:0]           dr_reg;
    logic signed [OFFSET_BITS-1:0]           dc_reg;
    logic signed [2*OFFSET_BITS-1:0]         sq_row;
    logic signed [2*OFFSET_BITS-1:0]         sq_col;
    logic [DIST_BITS-1:0]                    dist_next;
    logic [DIST_BITS-1:0]                    dist_reg;
    logic [DIST_BITS+PHASE_BITS-1:0]         phase_prod;
    logic [PHASE_BITS-1:0]                   phase_next;
    logic [PHASE_BITS-1:0]                   phase_reg;
    pix_t                                    pix0_reg;
    pix_t                                    pix1_reg;
    pix_t                                    pix2_reg;

    assign centre_row = SIZE_BITS'(image_rows[SIZE_BITS-1:1]) + SIZE_BITS'(1);
    assign centre_col = SIZE_BITS'(image_cols[SIZE_BITS-1:1]) + SIZE_BITS'(1);
    assign dr_next    = $signed({2'b00, pix_row}) - $signed({1'b0, centre_row});
    assign dc_next    = $signed({2'b00, pix_col}) - $signed({1'b0, centre_col});

    assign sq_row     = dr_reg * dr_reg;
    assign sq_col     = dc_reg * dc_reg;
    assign dist_next  = DIST_BITS'(sq_row[SQ_BITS-1:0]) + DIST_BITS'(sq_col[SQ_BITS-1:0]);

    // whole turns drop out of the product
    assign phase_prod = dist_reg * phase_coef;
    assign phase_next = phase_prod[PHASE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            dr_reg   <= dr_next;
            dc_reg   <= dc_next;
            pix0_reg <= pix_in;
        end
        if (ctl.load[1])
        begin
            dist_reg <= dist_next;
            pix1_reg <= pix0_reg;
        end
        if (ctl.load[2])
        begin
            phase_reg <= phase_next;
            pix2_reg  <= pix1_reg;
        end
    end

    assign phase   = phase_reg;
    assign pix_out = pix2_reg;

endmodule

/* sv/qpcr_trig.sv */
// phase to table index, quarter-wave lookup and quadrant fold
module qpcr_trig (
    input  logic                            clk,
    input  qpcr_pkg::pipe_ctl_t             ctl,
    input  logic [qpcr_pkg::PHASE_BITS-1:0] phase,
    input  qpcr_pkg::pix_t                  pix_in,
    output logic signed [qpcr_pkg::SC_BITS-1:0] sin_val,
    output logic signed [qpcr_pkg::SC_BITS-1:0] cos_val,
    output qpcr_pkg::pix_t                  pix_out
);
    import qpcr_pkg::*;

    logic [PHASE_BITS:0]           phase_rnd;
    logic [TABLE_ADDR_BITS-1:0]    idx;
    logic [1:0]                    quad;
    logic [QUARTER_BITS-1:0]       r_idx;
    logic [QUARTER_BITS:0]         c_idx;
    logic signed [SC_BITS-1:0]     s_r;
    logic signed [SC_BITS-1:0]     s_c;
    logic signed [SC_BITS-1:0]     sin_next;
    logic signed [SC_BITS-1:0]     cos_next;
    logic signed [SC_BITS-1:0]     sin_reg;
    logic signed [SC_BITS-1:0]     cos_reg;
    pix_t                          pix_reg;

    // round to nearest entry, top entry wraps to zero
    assign phase_rnd = {1'b0, phase} + ((PHASE_BITS+1)'(1) << (PHASE_BITS - 1 - TABLE_ADDR_BITS));
    assign idx       = phase_rnd[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign quad      = idx[TABLE_ADDR_BITS-1 -: 2];
    assign r_idx     = idx[QUARTER_BITS-1:0];
    assign c_idx     = (QUARTER_BITS+1)'(QUARTER) - {1'b0, r_idx};
    assign s_r       = $signed({1'b0, QSIN_TABLE[{1'b0, r_idx}]});
    assign s_c       = $signed({1'b0, QSIN_TABLE[c_idx]});

    always_comb
    begin
        case (quad)
            2'd0:
            begin
                sin_next = s_r;
                cos_next = s_c;
            end
            2'd1:
            begin
                sin_next = s_c;
                cos_next = -s_r;
            end
            2'd2:
            begin
                sin_next = -s_r;
                cos_next = -s_c;
            end
            default:
            begin
                sin_next = -s_c;
                cos_next = s_r;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
            pix_reg <= pix_in;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
    assign pix_out = pix_reg;

endmodule

/* sv/qpcr_rotate.sv */
// complex multiply by the unit phasor, round and saturate, two stages
module qpcr_rotate (
    input  logic                                clk,
    input  qpcr_pkg::pipe_ctl_t                 ctl,
    input  logic signed [qpcr_pkg::SC_BITS-1:0] sin_val,
    input  logic signed [qpcr_pkg::SC_BITS-1:0] cos_val,
    input  qpcr_pkg::pix_t                      pix_in,
    output qpcr_pkg::pix_t                      pix_out
);
    import qpcr_pkg::*;

    localparam int SH_BITS = ACC_BITS - TRIG_FRAC;

    logic signed [PROD_BITS-1:0] re_cos_reg;
    logic signed [PROD_BITS-1:0] im_sin_reg;
    logic signed [PROD_BITS-1:0] re_sin_reg;
    logic signed [PROD_BITS-1:0] im_cos_reg;
    logic signed [ACC_BITS-1:0]  re_acc;
    logic signed [ACC_BITS-1:0]  im_acc;
    pix_t                        res_next;
    pix_t                        res_reg;

    function automatic logic signed [PIXEL_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ACC_BITS-1:0] rnd;
        logic signed [SH_BITS-1:0]  q;
        logic signed [SH_BITS-1:0]  hi;
        logic signed [SH_BITS-1:0]  lo;
        rnd = v + (ACC_BITS'(1) <<< (TRIG_FRAC - 1));
        q   = SH_BITS'(rnd >>> TRIG_FRAC);
        hi  = (SH_BITS'(1) <<< (PIXEL_BITS - 1)) - SH_BITS'(1);
        lo  = -hi - SH_BITS'(1);
        if (q > hi)
            q = hi;
        else if (q < lo)
            q = lo;
        return q[PIXEL_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            re_cos_reg <= pix_in.re * cos_val;
            im_sin_reg <= pix_in.im * sin_val;
            re_sin_reg <= pix_in.re * sin_val;
            im_cos_reg <= pix_in.im * cos_val;
        end
        if (ctl.load[5])
            res_reg <= res_next;
    end

    assign re_acc      = ACC_BITS'(re_cos_reg) - ACC_BITS'(im_sin_reg);
    assign im_acc      = ACC_BITS'(re_sin_reg) + ACC_BITS'(im_cos_reg);
    assign res_next.re = round_sat(re_acc);
    assign res_next.im = round_sat(im_acc);
    assign pix_out     = res_reg;

endmodule

/* sv/quadratic_phase_chirp_rotate.sv */
// top level: config registers, pipeline valid/ready control, stream ports
// a pixel accepted at the input moves through every stage register in turn to m_tvalid
// throughput: one pixel per clock while m_tready stays high; six register
// stages, each loads whenever it is empty or the stage after it moves on
// reset: rst_n clears all stage valid bits and sets image_rows/image_cols to 1024
// and phase_coef to 0
`include "quadratic_phase_chirp_rotate_macros.svh"

module quadratic_phase_chirp_rotate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qpcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [qpcr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pix_row[11:0], pix_col[23:12], re_in[41:24], im_in[59:42], zero [63:60]
    input  logic [qpcr_pkg::IN_DATA_BITS-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // re_out[17:0], im_out[35:18], zero [39:36]
    output logic [qpcr_pkg::OUT_DATA_BITS-1:0]    m_tdata
);
    import qpcr_pkg::*;

    logic [SIZE_BITS-1:0]         image_rows_reg;
    logic [SIZE_BITS-1:0]         image_cols_reg;
    logic [PHASE_BITS-1:0]        phase_coef_reg;
    logic [NUM_STAGES-1:0]        valid_reg;
    logic [NUM_STAGES-1:0]        valid_next;
    logic [NUM_STAGES-1:0]        stage_rdy;
    pipe_ctl_t                    ctl;
    logic [COORD_BITS-1:0]        pix_row;
    logic [COORD_BITS-1:0]        pix_col;
    pix_t                         pix_in;
    logic [PHASE_BITS-1:0]        phase;
    pix_t                         pix_ph;
    logic signed [SC_BITS-1:0]    sin_val;
    logic signed [SC_BITS-1:0]    cos_val;
    pix_t                         pix_tr;
    pix_t                         pix_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg <= ROWS_RESET;
            image_cols_reg <= COLS_RESET;
            phase_coef_reg <= COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_COLS: image_cols_reg <= cfg_data[SIZE_BITS-1:0];
                CFG_PHASE_COEF: phase_coef_reg <= cfg_data[PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage takes new data when empty or when the next stage takes its data
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
    end

    always_comb
    begin
        valid_next[0] = stage_rdy[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
            valid_next[i] = stage_rdy[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctl.load  = stage_rdy;
    assign s_tready  = stage_rdy[0];
    assign m_tvalid  = valid_reg[NUM_STAGES-1];

    assign pix_row   = s_tdata[COORD_BITS-1:0];
    assign pix_col   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pix_in.re = s_tdata[2*COORD_BITS+PIXEL_BITS-1:2*COORD_BITS];
    assign pix_in.im = s_tdata[2*COORD_BITS+2*PIXEL_BITS-1:2*COORD_BITS+PIXEL_BITS];

    qpcr_phase u_phase (
        .clk        (clk),
        .ctl        (ctl),
        .image_rows (image_rows_reg),
        .image_cols (image_cols_reg),
        .phase_coef (phase_coef_reg),
        .pix_row    (pix_row),
        .pix_col    (pix_col),
        .pix_in     (pix_in),
        .phase      (phase),
        .pix_out    (pix_ph)
    );

    qpcr_trig u_trig (
        .clk     (clk),
        .ctl     (ctl),
        .phase   (phase),
        .pix_in  (pix_ph),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .pix_out (pix_tr)
    );

    qpcr_rotate u_rotate (
        .clk     (clk),
        .ctl     (ctl),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .pix_in  (pix_tr),
        .pix_out (pix_res)
    );

    assign m_tdata = {(OUT_DATA_BITS - 2*PIXEL_BITS)'(0), pix_res.im, pix_res.re};

    `QPCR_ASSERT_NOW(a_drain_frees_input, m_tvalid && m_tready, s_tready,
        "input not ready while output drains")
    `QPCR_ASSERT_NOW(a_empty_out_frees_input, !m_tvalid, s_tready,
        "input not ready with empty output stage")
    `QPCR_ASSERT_NEXT(a_accept_enters_pipe, s_tvalid && s_tready, valid_reg[0],
        "accepted transaction missing from first stage")

endmodule
